>>> sv/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Holds the request and response transfer formats, the stored entry format
// and the control bundle that drives every cell of the chain.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int SPQ_DEPTH     = 16;
   localparam int PRIO_WIDTH    = 16;
   localparam int PAYLOAD_WIDTH = 32;
   localparam int COUNT_WIDTH   = $clog2(SPQ_DEPTH + 1);

   typedef enum logic [1:0] {
      REQ_ENQUEUE = 2'd0,
      REQ_DEQUEUE = 2'd1,
      REQ_PEEK    = 2'd2,
      REQ_CLEAR   = 2'd3
   } spq_req_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } spq_status_type;

   typedef struct packed {
      spq_req_type              req_type;
      logic [PRIO_WIDTH-1:0]    in_priority;
      logic [PAYLOAD_WIDTH-1:0] in_payload;
   } spq_request_type;

   typedef struct packed {
      spq_status_type           status;
      logic [PRIO_WIDTH-1:0]    out_priority;
      logic [PAYLOAD_WIDTH-1:0] out_payload;
      logic [COUNT_WIDTH-1:0]   count;
   } spq_response_type;

   typedef struct packed {
      logic [PRIO_WIDTH-1:0]    prio;
      logic [PAYLOAD_WIDTH-1:0] payload;
   } spq_entry_type;

   typedef struct packed {
      logic insert;
      logic remove;
   } spq_cell_ctrl_type;

endpackage
`default_nettype wire

>>> sv/spq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry. On insert it keeps its entry, takes the new entry or takes
// its front neighbor's entry; on remove it takes its back neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
   input  wire                        clock,
   input  spq_pkg::spq_cell_ctrl_type ctrl,
   input  spq_pkg::spq_entry_type     new_entry,
   input  spq_pkg::spq_entry_type     prev_entry,
   input  wire                        prev_below,
   input  spq_pkg::spq_entry_type     next_entry,
   input  wire                        occupied,
   output spq_pkg::spq_entry_type     entry,
   output logic                       below
);
   import spq_pkg::*;

   spq_entry_type entry_ff;
   spq_entry_type entry_in;

   // The new entry goes behind every stored entry of equal or higher priority.
   assign below = occupied && (entry_ff.prio >= new_entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (below) begin
            entry_in = entry_ff;
         end else if (prev_below) begin
            entry_in = new_entry;
         end else begin
            entry_in = prev_entry;
         end
      end else if (ctrl.remove) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

>>> sv/sorted_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue: priority queue kept as a sorted chain of cells
// Cell 0 holds the front entry; each cell compares its priority with the
// incoming one and shifts in step with its neighbors.
//
//   Channel  Ports                           Direction  Transfer format
//   req      req_valid req_stall req_data    in         spq_request_type
//   rsp      rsp_valid rsp_stall rsp_data    out        spq_response_type
//
// One request is taken per cycle while req_stall is low; its response is registered and appears in the next cycle.
// All cells compare and shift together, in the cycle in which the request is taken.
// Reset clears the count and the response valid; no clearing pass is run.
// req_stall is high while a response is held and rsp_stall is high.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  spq_pkg::spq_request_type  req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output spq_pkg::spq_response_type rsp_data
);
   import spq_pkg::*;

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   spq_response_type       rsp_data_ff;
   spq_response_type       rsp_data_in;

   logic              accept;
   logic              full;
   logic              empty;
   spq_cell_ctrl_type ctrl;
   spq_entry_type     new_entry;
   spq_entry_type     cell_entry [SPQ_DEPTH];
   logic              cell_below [SPQ_DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == COUNT_WIDTH'(SPQ_DEPTH));
   assign empty     = (count_ff == '0);
   assign new_entry = '{prio: req_data.in_priority, payload: req_data.in_payload};

   assign ctrl.insert = accept && (req_data.req_type == REQ_ENQUEUE) && !full;
   assign ctrl.remove = accept && (req_data.req_type == REQ_DEQUEUE) && !empty;

   for (genvar k = 0; k < SPQ_DEPTH; k++) begin : g_cell
      spq_entry_type prev_entry;
      logic          prev_below;
      spq_entry_type next_entry;

      if (k == 0) begin : g_head
         assign prev_entry = new_entry;
         assign prev_below = 1'b1;
      end else begin : g_body
         assign prev_entry = cell_entry[k-1];
         assign prev_below = cell_below[k-1];
      end

      if (k == SPQ_DEPTH - 1) begin : g_tail
         assign next_entry = cell_entry[k];
      end else begin : g_link
         assign next_entry = cell_entry[k+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .new_entry  (new_entry),
         .prev_entry (prev_entry),
         .prev_below (prev_below),
         .next_entry (next_entry),
         .occupied   (count_ff > COUNT_WIDTH'(k)),
         .entry      (cell_entry[k]),
         .below      (cell_below[k])
      );
   end

   always_comb begin
      count_in    = count_ff;
      rsp_data_in = rsp_data_ff;
      if (accept) begin
         rsp_data_in.status       = STATUS_OK;
         rsp_data_in.out_priority = '0;
         rsp_data_in.out_payload  = '0;
         unique case (req_data.req_type)
            REQ_ENQUEUE: begin
               if (full) begin
                  rsp_data_in.status = STATUS_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            REQ_DEQUEUE, REQ_PEEK: begin
               if (empty) begin
                  rsp_data_in.status = STATUS_EMPTY;
               end else begin
                  rsp_data_in.out_priority = cell_entry[0].prio;
                  rsp_data_in.out_payload  = cell_entry[0].payload;
                  if (req_data.req_type == REQ_DEQUEUE) begin
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            REQ_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
         rsp_data_in.count = count_in;
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(SPQ_DEPTH))
      else $error("entry count exceeds depth");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert |=> count_ff == $past(count_ff) + 1'b1)
      else $error("enqueue did not grow the count");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.remove |=> count_ff == $past(count_ff) - 1'b1)
      else $error("dequeue did not shrink the count");

   a_clear_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.req_type == REQ_CLEAR) |=> rsp_valid_ff && rsp_data_ff.count == '0)
      else $error("clear response does not report an empty store");

endmodule
`default_nettype wire
